// File: rtl/trk2_pkg.sv
// ----------------------------------------------------------------------------
// trk2_pkg
// shared types and constants for the track-2 field extractor
// ----------------------------------------------------------------------------
package trk2_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned EXPIRY_W   = 32;
  localparam int unsigned SERVICE_W  = 24;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [CHAR_W-1:0]  SEPARATOR     = 8'h3D;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 6'd63;
  localparam logic [COUNT_W:0]   FOLLOW_NEEDED = 7'd8;
  localparam logic [COUNT_W-1:0] EXPIRY_LAST   = 6'd4;
  localparam logic [COUNT_W-1:0] SERVICE_LAST  = 6'd7;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage

// File: rtl/track2_field_extractor_top.sv
// ----------------------------------------------------------------------------
// track2_field_extractor_top
// parses a track-2 character stream into account-number characters and a
// summary of account-number length, expiry and service code
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while the block is idle. A zero byte, or
// a request with in_tlast set, ends the string; the block then stops taking
// requests and a small sequencer steps an index through the stored account
// number (only when pan_ok), one result per cycle while the output is not
// stalled, into the output register, followed by the summary with out_tlast
// set. With pan_ok and the separator at position p, p account-number results
// precede the summary; otherwise only the summary. After a zero byte without
// the end mark, requests are dropped until one arrives with in_tlast set.
module track2_field_extractor_top #(
  parameter int unsigned MAX_PAN_CHARS = 19,
  parameter int unsigned MIN_PAN_CHARS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [trk2_pkg::CHAR_W-1:0]       in_tdata,  // track_byte
  input  logic                              in_tlast,  // end_of_string
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pan_char, pan_index, pan_length, pan_ok, fields_ok, expiry_chars,
  // service_chars, zero pad
  output logic [trk2_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser,  // is_summary
  output logic                              out_tlast   // last
);
  import trk2_pkg::*;

  localparam int unsigned IDX_W = (MAX_PAN_CHARS > 1) ? $clog2(MAX_PAN_CHARS) : 1;

  state_t                 state_r, state_nxt;
  logic [COUNT_W-1:0]     char_count_r, char_count_nxt;
  logic [POS_W-1:0]       sep_pos_r, sep_pos_nxt;
  logic                   sep_found_r, sep_found_nxt;
  logic                   search_over_r, search_over_nxt;
  logic                   string_ended_r, string_ended_nxt;
  logic                   ended_zero_r, ended_zero_nxt;
  logic [EXPIRY_W-1:0]    expiry_r, expiry_nxt;
  logic [SERVICE_W-1:0]   service_r, service_nxt;
  logic [POS_W-1:0]       k_r, k_nxt;

  logic [CHAR_W-1:0]      pan_store [MAX_PAN_CHARS];
  logic                   store_we;
  logic [IDX_W-1:0]       store_idx;

  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic                   out_user_r;
  logic                   out_last_r;

  logic                   in_acc;
  logic                   byte_zero;
  logic                   load;
  logic                   pan_ok;
  logic                   fields_ok;
  logic                   emit_char;
  logic [COUNT_W-1:0]     offset;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign byte_zero = (in_tdata == '0);
  assign load      = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign pan_ok    = sep_found_r && (sep_pos_r >= POS_W'(MIN_PAN_CHARS));
  assign fields_ok = sep_found_r &&
                     ({1'b0, char_count_r} >= ({2'b00, sep_pos_r} + FOLLOW_NEEDED));
  assign emit_char = pan_ok && (k_r < sep_pos_r);
  assign offset    = char_count_r - {1'b0, sep_pos_r};

  always_comb begin
    state_nxt        = state_r;
    char_count_nxt   = char_count_r;
    sep_pos_nxt      = sep_pos_r;
    sep_found_nxt    = sep_found_r;
    search_over_nxt  = search_over_r;
    string_ended_nxt = string_ended_r;
    ended_zero_nxt   = ended_zero_r;
    expiry_nxt       = expiry_r;
    service_nxt      = service_r;
    k_nxt            = k_r;
    store_we         = 1'b0;
    store_idx        = char_count_r[IDX_W-1:0];

    if (in_acc) begin
      if (string_ended_r) begin
        if (in_tlast) begin
          string_ended_nxt = 1'b0;
        end
      end else begin
        if (!byte_zero) begin
          if (!search_over_r) begin
            if (char_count_r < COUNT_W'(MAX_PAN_CHARS)) begin
              if (in_tdata == SEPARATOR) begin
                sep_found_nxt   = 1'b1;
                sep_pos_nxt     = char_count_r[POS_W-1:0];
                search_over_nxt = 1'b1;
              end else begin
                store_we = 1'b1;
              end
            end else begin
              search_over_nxt = 1'b1;
            end
          end else if (sep_found_r && (char_count_r > {1'b0, sep_pos_r})) begin
            if (offset <= EXPIRY_LAST) begin
              expiry_nxt = {expiry_r[EXPIRY_W-CHAR_W-1:0], in_tdata};
            end else if (offset <= SERVICE_LAST) begin
              service_nxt = {service_r[SERVICE_W-CHAR_W-1:0], in_tdata};
            end
          end
          if (char_count_r < COUNT_MAX) begin
            char_count_nxt = char_count_r + 1'b1;
          end
        end
        if (byte_zero || in_tlast) begin
          state_nxt      = ST_EMIT;
          k_nxt          = '0;
          ended_zero_nxt = byte_zero && !in_tlast;
        end
      end
    end

    if (load) begin
      if (emit_char) begin
        k_nxt = k_r + 1'b1;
      end else begin
        state_nxt        = ST_IDLE;
        char_count_nxt   = '0;
        sep_pos_nxt      = '0;
        sep_found_nxt    = 1'b0;
        search_over_nxt  = 1'b0;
        expiry_nxt       = '0;
        service_nxt      = '0;
        string_ended_nxt = ended_zero_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      char_count_r   <= '0;
      sep_pos_r      <= '0;
      sep_found_r    <= 1'b0;
      search_over_r  <= 1'b0;
      string_ended_r <= 1'b0;
      ended_zero_r   <= 1'b0;
      expiry_r       <= '0;
      service_r      <= '0;
      k_r            <= '0;
    end else begin
      state_r        <= state_nxt;
      char_count_r   <= char_count_nxt;
      sep_pos_r      <= sep_pos_nxt;
      sep_found_r    <= sep_found_nxt;
      search_over_r  <= search_over_nxt;
      string_ended_r <= string_ended_nxt;
      ended_zero_r   <= ended_zero_nxt;
      expiry_r       <= expiry_nxt;
      service_r      <= service_nxt;
      k_r            <= k_nxt;
    end
  end

  // account-number store
  always_ff @(posedge clk) begin
    if (store_we) begin
      pan_store[store_idx] <= in_tdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_char) begin
        out_data_r <= {4'b0000, {SERVICE_W{1'b0}}, {EXPIRY_W{1'b0}}, 1'b0, 1'b0,
                       {POS_W{1'b0}}, k_r, pan_store[k_r[IDX_W-1:0]]};
        out_user_r <= 1'b0;
        out_last_r <= 1'b0;
      end else begin
        out_data_r <= {4'b0000,
                       fields_ok ? service_r : {SERVICE_W{1'b0}},
                       fields_ok ? expiry_r : {EXPIRY_W{1'b0}},
                       fields_ok, pan_ok,
                       sep_found_r ? sep_pos_r : {POS_W{1'b0}},
                       {POS_W{1'b0}}, {CHAR_W{1'b0}}};
        out_user_r <= 1'b1;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the track-2 field extractor: a stream driver
// sends card strings in random bursts, a predictor builds the account-number
// and summary results each accepted request should cause, and a monitor
// compares every result from the block against them under random stalls
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trk2_pkg::*;

  localparam int unsigned PAN_MAX     = 19;
  localparam int unsigned PAN_MIN     = 12;
  localparam int unsigned FOLLOW_MIN  = 7;
  localparam int unsigned ITEM_GOAL   = 330;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 40;

  typedef struct {
    logic [CHAR_W-1:0] chr;
    logic              eos;
  } track_item_t;

  typedef struct {
    logic                 summary;
    logic [CHAR_W-1:0]    ch;
    logic [POS_W-1:0]     idx;
    logic [POS_W-1:0]     plen;
    logic                 pok;
    logic                 fok;
    logic [EXPIRY_W-1:0]  expiry;
    logic [SERVICE_W-1:0] svc;
    logic                 lst;
  } card_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [CHAR_W-1:0]     in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  track_item_t  track_chars_q[$];
  card_result_t card_results_q[$];

  // predictor copy of the block state
  logic [CHAR_W-1:0]    pan_chars [PAN_MAX];
  logic [COUNT_W-1:0]   seen_count;
  logic [POS_W-1:0]     sep_at;
  logic                 sep_seen;
  logic                 search_done;
  logic                 skip_to_end;
  logic [EXPIRY_W-1:0]  expiry_acc;
  logic [SERVICE_W-1:0] service_acc;

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  logic        in_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned run_left = 0;

  track2_field_extractor_top #(
    .MAX_PAN_CHARS(PAN_MAX),
    .MIN_PAN_CHARS(PAN_MIN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic clear_card();
    for (int k = 0; k < PAN_MAX; k++) pan_chars[k] = '0;
    seen_count  = '0;
    sep_at      = '0;
    sep_seen    = 1'b0;
    search_done = 1'b0;
    expiry_acc  = '0;
    service_acc = '0;
  endtask

  task automatic take_track_char(input logic [CHAR_W-1:0] b);
    int pos;
    int off;
    pos = int'(seen_count);
    if (!search_done) begin
      if (pos < PAN_MAX) begin
        if (b == SEPARATOR) begin
          sep_seen    = 1'b1;
          sep_at      = pos[POS_W-1:0];
          search_done = 1'b1;
        end else begin
          pan_chars[pos] = b;
        end
      end else begin
        search_done = 1'b1;
      end
    end else if (sep_seen && pos > int'(sep_at)) begin
      off = pos - int'(sep_at);
      if (off <= 4) expiry_acc = {expiry_acc[EXPIRY_W-CHAR_W-1:0], b};
      else if (off <= 7) service_acc = {service_acc[SERVICE_W-CHAR_W-1:0], b};
    end
    if (seen_count < COUNT_MAX) seen_count = seen_count + 1'b1;
  endtask

  task automatic emit_card_fields();
    card_result_t r;
    logic         pan_good;
    logic         fields_good;
    pan_good    = sep_seen && (int'(sep_at) >= PAN_MIN);
    fields_good = sep_seen && ((int'(seen_count) - int'(sep_at) - 1) >= FOLLOW_MIN);
    if (pan_good) begin
      for (int k = 0; k < int'(sep_at) && k < PAN_MAX; k++) begin
        r = '{summary: 1'b0, ch: pan_chars[k], idx: k[POS_W-1:0], plen: '0, pok: 1'b0,
              fok: 1'b0, expiry: '0, svc: '0, lst: 1'b0};
        card_results_q.push_back(r);
      end
    end
    r = '{summary: 1'b1, ch: '0, idx: '0, plen: sep_seen ? sep_at : '0, pok: pan_good,
          fok: fields_good, expiry: fields_good ? expiry_acc : '0,
          svc: fields_good ? service_acc : '0, lst: 1'b1};
    card_results_q.push_back(r);
  endtask

  task automatic parse_track_char(input track_item_t it);
    if (skip_to_end) begin
      if (it.eos) skip_to_end = 1'b0;
    end else begin
      if (it.chr != '0) take_track_char(it.chr);
      if (it.chr == '0 || it.eos) begin
        emit_card_fields();
        clear_card();
        skip_to_end = (it.chr == '0) && !it.eos;
      end
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // stimulus helpers
  function automatic logic [CHAR_W-1:0] pan_byte();
    logic [CHAR_W-1:0] b;
    if ($urandom_range(0, 4) != 0) return CHAR_W'(8'h30 + $urandom_range(0, 9));
    b = CHAR_W'($urandom_range(1, 255));
    if (b == SEPARATOR) b = 8'hFF;
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] noise_byte();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SEPARATOR;
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_char(input logic [CHAR_W-1:0] b, input logic eos);
    track_item_t it;
    it.chr = b;
    it.eos = eos;
    track_chars_q.push_back(it);
  endtask

  task automatic finish_string(input int style);
    case (style)
      0: track_chars_q[track_chars_q.size()-1].eos = 1'b1;
      1: push_char('0, 1'b1);
      default: begin
        push_char('0, 1'b0);
        repeat ($urandom_range(0, 3)) push_char(noise_byte(), 1'b0);
        push_char(noise_byte(), 1'b1);
      end
    endcase
  endtask

  task automatic queue_card_string();
    int kind;
    int plen;
    int follow;
    kind = $urandom_range(0, 19);
    if (kind < 16) begin
      plen   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11) : $urandom_range(12, 18);
      follow = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(7, 12);
      if (kind == 15) follow = $urandom_range(45, 55);
      repeat (plen) push_char(pan_byte(), 1'b0);
      push_char(SEPARATOR, 1'b0);
      repeat (follow) begin
        if ($urandom_range(0, 2) == 0) push_char(CHAR_W'($urandom_range(1, 255)), 1'b0);
        else push_char(CHAR_W'(8'h30 + $urandom_range(0, 9)), 1'b0);
      end
      finish_string($urandom_range(0, 2));
    end else if (kind < 18) begin
      repeat ($urandom_range(19, 24)) push_char(pan_byte(), 1'b0);
      finish_string($urandom_range(0, 2));
    end else begin
      repeat ($urandom_range(1, 30)) push_char(noise_byte(), ($urandom_range(0, 9) == 0));
      finish_string(0);
    end
  endtask

  // request side: bursts with random gaps, some long bursts without gaps
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (track_chars_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= track_chars_q[0].chr;
        in_tlast  <= track_chars_q[0].eos;
        if (burst_left <= 1) begin
          if ($urandom_range(0, 6) == 0) begin
            burst_left = $urandom_range(40, 80);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      parse_track_char(track_chars_q.pop_front());
      in_taken = 1'b1;
    end
  end

  // result side stalls
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (run_left != 0) begin
        run_left--;
      end else begin
        run_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
        stall_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk) begin
    card_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (card_results_q.size() == 0) begin
        note_mismatch("result with nothing expected");
      end else begin
        want = card_results_q.pop_front();
        check_field("is_summary", 32'(out_tuser), 32'(want.summary));
        check_field("pan_char", 32'(out_tdata[7:0]), 32'(want.ch));
        check_field("pan_index", 32'(out_tdata[12:8]), 32'(want.idx));
        check_field("pan_length", 32'(out_tdata[17:13]), 32'(want.plen));
        check_field("pan_ok", 32'(out_tdata[18]), 32'(want.pok));
        check_field("fields_ok", 32'(out_tdata[19]), 32'(want.fok));
        check_field("expiry_chars", out_tdata[51:20], want.expiry);
        check_field("service_chars", 32'(out_tdata[75:52]), 32'(want.svc));
        check_field("last", 32'(out_tlast), 32'(want.lst));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[track2_field_extractor_top] ERROR");
      $finish;
    end
  end

  initial begin
    clear_card();
    skip_to_end = 1'b0;

    // separator first, seven characters after it, end mark on the last one
    push_char(SEPARATOR, 1'b0);
    push_char("2", 1'b0); push_char("9", 1'b0); push_char("1", 1'b0);
    push_char("2", 1'b0); push_char("1", 1'b0); push_char("0", 1'b0);
    push_char(8'hFF, 1'b1);
    // single top byte with end mark, then an empty string
    push_char(8'hFF, 1'b1);
    push_char(8'h00, 1'b1);
    // zero without end mark: following requests dropped until the end mark
    push_char("4", 1'b0); push_char("5", 1'b0); push_char(8'h00, 1'b0);
    push_char(8'h41, 1'b0); push_char(8'h00, 1'b0); push_char(SEPARATOR, 1'b1);
    push_char(8'h00, 1'b0); push_char(8'h00, 1'b1);
    // early separator with only six characters following
    push_char(8'h01, 1'b0); push_char(SEPARATOR, 1'b0);
    push_char("1", 1'b0); push_char("2", 1'b0); push_char("3", 1'b0);
    push_char("4", 1'b0); push_char("5", 1'b0); push_char(8'hFE, 1'b0);
    push_char(8'h00, 1'b1);

    while (track_chars_q.size() < ITEM_GOAL) queue_card_string();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (track_chars_q.size() != 0) @(posedge clk);
    while (card_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("[track2_field_extractor_top] OK");
    end else begin
      $display("[track2_field_extractor_top] ERROR");
    end
    $finish;
  end

endmodule
